/* rtl/space_to_batch_index_gen_macros.svh */
// assertion macros for the space-to-batch index generator
// used by space_to_batch_index_gen.sv, no other dependencies
`ifndef SPACE_TO_BATCH_INDEX_GEN_MACROS_SVH
`define SPACE_TO_BATCH_INDEX_GEN_MACROS_SVH

// implication checked in the same cycle
`define S2B_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the next cycle
`define S2B_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/s2b_pkg.sv */
// shared widths, register codes and pipeline types for the space-to-batch
// index generator; no dependencies
`timescale 1ns / 1ps

package s2b_pkg;

    // register port
    localparam int DATA_W = 32;
    localparam int ADDR_W = 5;

    // field and register widths
    localparam int OB_W   = 16;
    localparam int CH_W   = 12;
    localparam int IDX_W  = 44;
    localparam int NB_W   = 9;
    localparam int DIM_W  = 13;
    localparam int BLK_W  = 5;
    localparam int PAD_W  = 8;
    localparam int NBW_W  = NB_W + BLK_W;
    localparam int SHBW_W = OB_W + BLK_W;

    // divider pipeline: quotient bits resolved per stage
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = OB_W / DIV_STEP;

    localparam logic [NB_W-1:0]  ONE_NB  = 9'd1;
    localparam logic [BLK_W-1:0] ONE_BLK = 5'd1;
    localparam logic [DIM_W-1:0] ONE_DIM = 13'd1;

    // register map, index = byte address / 4
    typedef enum logic [2:0] {
        REG_IN_BATCHES    = 3'd0,
        REG_IN_HEIGHT     = 3'd1,
        REG_IN_WIDTH      = 3'd2,
        REG_IN_DEPTH      = 3'd3,
        REG_BLOCK_HEIGHT  = 3'd4,
        REG_BLOCK_WIDTH   = 3'd5,
        REG_PAD_TOP_ROWS  = 3'd6,
        REG_PAD_LEFT_COLS = 3'd7
    } t_reg_idx;

    // one divider stage: two restoring divisions share the numerator
    typedef struct packed {
        logic [OB_W-1:0]  num;
        logic [NB_W-1:0]  rem_a;
        logic [OB_W-1:0]  quo_a;
        logic [NBW_W-1:0] rem_b;
        logic [OB_W-1:0]  quo_b;
        logic [CH_W-1:0]  chan;
    } t_div;

endpackage

/* rtl/space_to_batch_index_gen.sv */
// space-to-batch source index generator: register port, divider pipeline,
// window check and index multiply chain
// depends on s2b_pkg and space_to_batch_index_gen_macros.svh
`timescale 1ns / 1ps
`include "space_to_batch_index_gen_macros.svh"

// Usage
// Input channel i_valid / o_stall carries one output element position per
// transaction (i_out_batch, i_out_row, i_out_col, i_chan). Output channel
// o_valid / i_stall returns one result per transaction: o_is_pad and
// o_source_index, the linear element index in the input tensor (zero for
// padding). Layout is NHWC with CHANNELS_LAST = 1, NCHW otherwise.
// One transaction is taken every cycle while o_stall is low. The pipeline
// depth is set by the batch divider, which resolves two quotient bits per
// stage over eight stages, followed by the window check and the three-step
// multiply-add chain for the index.
// The geometry registers sit on an APB-style port and must be written between
// jobs, with the pipeline empty; the block itself does not enforce this.
// Reset clears the pipeline valid bits and loads the registers with batch,
// size and block values of 1 and paddings of 0.
// When the receiver stalls a waiting result, the whole pipeline holds and
// o_stall rises in the same cycle; nothing is lost or repeated.
module space_to_batch_index_gen #(
    parameter int CHANNELS_LAST = 1,
    parameter int COORD_BITS    = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [s2b_pkg::ADDR_W-1:0]    paddr,
    input  logic [s2b_pkg::DATA_W-1:0]    pwdata,
    output logic [s2b_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    // input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [s2b_pkg::OB_W-1:0]      i_out_batch,
    input  logic [COORD_BITS-1:0]         i_out_row,
    input  logic [COORD_BITS-1:0]         i_out_col,
    input  logic [s2b_pkg::CH_W-1:0]      i_chan,
    // output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_is_pad,
    output logic [s2b_pkg::IDX_W-1:0]     o_source_index
);

    localparam int DS      = s2b_pkg::DIV_STAGES;
    localparam int ST_M1   = DS + 1;
    localparam int ST_M2   = DS + 2;
    localparam int ST_M3   = DS + 3;
    localparam int ST_M4   = DS + 4;
    localparam int ST_X1   = DS + 5;
    localparam int ST_X2   = DS + 6;
    localparam int ST_X3   = DS + 7;
    localparam int ST_X4   = DS + 8;
    localparam int ST_X5   = DS + 9;
    localparam int ST_OUT  = DS + 10;

    localparam int PROD_W  = COORD_BITS + s2b_pkg::BLK_W;
    localparam int POS_W   = ((PROD_W > s2b_pkg::OB_W) ? PROD_W : s2b_pkg::OB_W) + 1;
    localparam int DIM_W   = s2b_pkg::DIM_W;
    localparam int T1_W    = s2b_pkg::NB_W + DIM_W;
    localparam int U1_W    = T1_W + 1;
    localparam int T2_W    = U1_W + DIM_W;
    localparam int U2_W    = T2_W + 1;
    localparam int LO_W    = 24;
    localparam int PLO_W   = LO_W + DIM_W;
    localparam int PHI_W   = U2_W - LO_W + DIM_W;
    localparam int IDX_W   = s2b_pkg::IDX_W;
    localparam int DATA_W  = s2b_pkg::DATA_W;

    // configuration registers
    logic [s2b_pkg::NB_W-1:0]  r_in_batches;
    logic [DIM_W-1:0]          r_in_height;
    logic [DIM_W-1:0]          r_in_width;
    logic [DIM_W-1:0]          r_in_depth;
    logic [s2b_pkg::BLK_W-1:0] r_block_height;
    logic [s2b_pkg::BLK_W-1:0] r_block_width;
    logic [s2b_pkg::PAD_W-1:0] r_pad_top_rows;
    logic [s2b_pkg::PAD_W-1:0] r_pad_left_cols;

    logic              w_wr;
    s2b_pkg::t_reg_idx w_reg;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_reg  = s2b_pkg::t_reg_idx'(paddr[s2b_pkg::ADDR_W-1:2]);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_batches    <= s2b_pkg::ONE_NB;
            r_in_height     <= s2b_pkg::ONE_DIM;
            r_in_width      <= s2b_pkg::ONE_DIM;
            r_in_depth      <= s2b_pkg::ONE_DIM;
            r_block_height  <= s2b_pkg::ONE_BLK;
            r_block_width   <= s2b_pkg::ONE_BLK;
            r_pad_top_rows  <= '0;
            r_pad_left_cols <= '0;
        end else if (w_wr) begin
            unique case (w_reg)
                s2b_pkg::REG_IN_BATCHES:    r_in_batches    <= pwdata[s2b_pkg::NB_W-1:0];
                s2b_pkg::REG_IN_HEIGHT:     r_in_height     <= pwdata[DIM_W-1:0];
                s2b_pkg::REG_IN_WIDTH:      r_in_width      <= pwdata[DIM_W-1:0];
                s2b_pkg::REG_IN_DEPTH:      r_in_depth      <= pwdata[DIM_W-1:0];
                s2b_pkg::REG_BLOCK_HEIGHT:  r_block_height  <= pwdata[s2b_pkg::BLK_W-1:0];
                s2b_pkg::REG_BLOCK_WIDTH:   r_block_width   <= pwdata[s2b_pkg::BLK_W-1:0];
                s2b_pkg::REG_PAD_TOP_ROWS:  r_pad_top_rows  <= pwdata[s2b_pkg::PAD_W-1:0];
                s2b_pkg::REG_PAD_LEFT_COLS: r_pad_left_cols <= pwdata[s2b_pkg::PAD_W-1:0];
            endcase
        end
    end

    // register read-back
    always_comb begin
        prdata = '0;
        unique case (w_reg)
            s2b_pkg::REG_IN_BATCHES:    prdata = DATA_W'(r_in_batches);
            s2b_pkg::REG_IN_HEIGHT:     prdata = DATA_W'(r_in_height);
            s2b_pkg::REG_IN_WIDTH:      prdata = DATA_W'(r_in_width);
            s2b_pkg::REG_IN_DEPTH:      prdata = DATA_W'(r_in_depth);
            s2b_pkg::REG_BLOCK_HEIGHT:  prdata = DATA_W'(r_block_height);
            s2b_pkg::REG_BLOCK_WIDTH:   prdata = DATA_W'(r_block_width);
            s2b_pkg::REG_PAD_TOP_ROWS:  prdata = DATA_W'(r_pad_top_rows);
            s2b_pkg::REG_PAD_LEFT_COLS: prdata = DATA_W'(r_pad_left_cols);
        endcase
    end

    // zero batch count or block size behaves as one
    logic [s2b_pkg::NB_W-1:0]  w_nb;
    logic [s2b_pkg::BLK_W-1:0] w_bh;
    logic [s2b_pkg::BLK_W-1:0] w_bw;
    logic [s2b_pkg::NBW_W-1:0] w_nbw;

    assign w_nb  = (r_in_batches == '0) ? s2b_pkg::ONE_NB : r_in_batches;
    assign w_bh  = (r_block_height == '0) ? s2b_pkg::ONE_BLK : r_block_height;
    assign w_bw  = (r_block_width == '0) ? s2b_pkg::ONE_BLK : r_block_width;
    // static between jobs, so the product is a quasi-constant divisor
    assign w_nbw = w_nb * w_bw;

    // pipeline advance and valid bits
    logic [ST_OUT:0] r_vld;
    logic            w_en;

    assign w_en    = !(r_vld[ST_OUT] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[ST_OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[ST_OUT-1:0], i_valid};
        end
    end

    // input register and divider stages
    // lane a: out_batch / in_batches, lane b: out_batch / (in_batches * block_width)
    s2b_pkg::t_div            r_div [0:DS];
    logic [COORD_BITS-1:0]    r_row [0:DS];
    logic [COORD_BITS-1:0]    r_col [0:DS];

    for (genvar k = 0; k <= DS; k++) begin : g_div
        s2b_pkg::t_div         n_div;
        logic [COORD_BITS-1:0] n_row;
        logic [COORD_BITS-1:0] n_col;

        if (k == 0) begin : g_in
            always_comb begin
                n_div.num   = i_out_batch;
                n_div.rem_a = '0;
                n_div.quo_a = '0;
                n_div.rem_b = '0;
                n_div.quo_b = '0;
                n_div.chan  = i_chan;
            end
            assign n_row = i_out_row;
            assign n_col = i_out_col;
        end else begin : g_step
            // two restoring steps per stage in each lane
            always_comb begin
                logic [s2b_pkg::NB_W:0]  ta;
                logic [s2b_pkg::NBW_W:0] tb;
                n_div = r_div[k-1];
                for (int j = 0; j < s2b_pkg::DIV_STEP; j++) begin
                    ta = {n_div.rem_a, n_div.num[s2b_pkg::OB_W-1]};
                    tb = {n_div.rem_b, n_div.num[s2b_pkg::OB_W-1]};
                    if (ta >= {1'b0, w_nb}) begin
                        n_div.rem_a = ta[s2b_pkg::NB_W-1:0] - w_nb;
                        n_div.quo_a = {n_div.quo_a[s2b_pkg::OB_W-2:0], 1'b1};
                    end else begin
                        n_div.rem_a = ta[s2b_pkg::NB_W-1:0];
                        n_div.quo_a = {n_div.quo_a[s2b_pkg::OB_W-2:0], 1'b0};
                    end
                    if (tb >= {1'b0, w_nbw}) begin
                        n_div.rem_b = tb[s2b_pkg::NBW_W-1:0] - w_nbw;
                        n_div.quo_b = {n_div.quo_b[s2b_pkg::OB_W-2:0], 1'b1};
                    end else begin
                        n_div.rem_b = tb[s2b_pkg::NBW_W-1:0];
                        n_div.quo_b = {n_div.quo_b[s2b_pkg::OB_W-2:0], 1'b0};
                    end
                    n_div.num = {n_div.num[s2b_pkg::OB_W-2:0], 1'b0};
                end
            end
            assign n_row = r_row[k-1];
            assign n_col = r_col[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_div[k] <= n_div;
                r_row[k] <= n_row;
                r_col[k] <= n_col;
            end
        end
    end

    // position stages: block shift, padded position, window check
    logic [s2b_pkg::OB_W-1:0]   r_m1_q;
    logic [s2b_pkg::OB_W-1:0]   r_m1_sh;
    logic [s2b_pkg::NB_W-1:0]   r_m1_sb;
    logic [s2b_pkg::CH_W-1:0]   r_m1_ch;
    logic [s2b_pkg::SHBW_W-1:0] r_m1_shbw;
    logic [PROD_W-1:0]          r_m1_rowp;
    logic [PROD_W-1:0]          r_m1_colp;

    logic [s2b_pkg::BLK_W-1:0]  r_m2_sw;
    logic [POS_W-1:0]           r_m2_pr;
    logic [PROD_W-1:0]          r_m2_colp;
    logic [s2b_pkg::NB_W-1:0]   r_m2_sb;
    logic [s2b_pkg::CH_W-1:0]   r_m2_ch;

    logic [POS_W-1:0]           r_m3_pc;
    logic                       r_m3_pad_r;
    logic                       r_m3_pad_ch;
    logic [DIM_W-1:0]           r_m3_r;
    logic [s2b_pkg::NB_W-1:0]   r_m3_sb;
    logic [s2b_pkg::CH_W-1:0]   r_m3_ch;

    logic                       r_m4_pad;
    logic [DIM_W-1:0]           r_m4_r;
    logic [DIM_W-1:0]           r_m4_c;
    logic [s2b_pkg::NB_W-1:0]   r_m4_sb;
    logic [s2b_pkg::CH_W-1:0]   r_m4_ch;

    logic [s2b_pkg::SHBW_W-1:0] w_sw_full;
    logic [POS_W-1:0]           w_r_full;
    logic [POS_W-1:0]           w_c_full;

    assign w_sw_full = s2b_pkg::SHBW_W'(r_m1_q) - r_m1_shbw;
    assign w_r_full  = r_m2_pr - POS_W'(r_pad_top_rows);
    assign w_c_full  = r_m3_pc - POS_W'(r_pad_left_cols);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // products of shift and coordinates with the block size
            r_m1_q    <= r_div[DS].quo_a;
            r_m1_sh   <= r_div[DS].quo_b;
            r_m1_sb   <= r_div[DS].rem_a;
            r_m1_ch   <= r_div[DS].chan;
            r_m1_shbw <= r_div[DS].quo_b * w_bw;
            r_m1_rowp <= r_row[DS] * w_bh;
            r_m1_colp <= r_col[DS] * w_bw;
            // column shift and padded row
            r_m2_sw   <= w_sw_full[s2b_pkg::BLK_W-1:0];
            r_m2_pr   <= POS_W'(r_m1_rowp) + POS_W'(r_m1_sh);
            r_m2_colp <= r_m1_colp;
            r_m2_sb   <= r_m1_sb;
            r_m2_ch   <= r_m1_ch;
            // padded column, row window and channel range
            r_m3_pc     <= POS_W'(r_m2_colp) + POS_W'(r_m2_sw);
            r_m3_pad_r  <= (r_m2_pr < POS_W'(r_pad_top_rows)) ||
                           (r_m2_pr >= POS_W'(r_pad_top_rows) + POS_W'(r_in_height));
            r_m3_pad_ch <= ({1'b0, r_m2_ch} >= r_in_depth);
            r_m3_r      <= w_r_full[DIM_W-1:0];
            r_m3_sb     <= r_m2_sb;
            r_m3_ch     <= r_m2_ch;
            // column window
            r_m4_pad <= r_m3_pad_r || r_m3_pad_ch ||
                        (r_m3_pc < POS_W'(r_pad_left_cols)) ||
                        (r_m3_pc >= POS_W'(r_pad_left_cols) + POS_W'(r_in_width));
            r_m4_c   <= w_c_full[DIM_W-1:0];
            r_m4_r   <= r_m3_r;
            r_m4_sb  <= r_m3_sb;
            r_m4_ch  <= r_m3_ch;
        end
    end

    // layout selection: index = ((sb*a1 + add1)*a2 + add2)*a3 + add3
    logic [DIM_W-1:0] w_a1;
    logic [DIM_W-1:0] w_a2;
    logic [DIM_W-1:0] w_a3;
    logic [DIM_W-1:0] w_add1;
    logic [DIM_W-1:0] w_add2;
    logic [DIM_W-1:0] w_add3;

    assign w_a1   = (CHANNELS_LAST != 0) ? r_in_height : r_in_depth;
    assign w_a2   = (CHANNELS_LAST != 0) ? r_in_width  : r_in_height;
    assign w_a3   = (CHANNELS_LAST != 0) ? r_in_depth  : r_in_width;
    assign w_add1 = (CHANNELS_LAST != 0) ? r_m4_r : DIM_W'(r_m4_ch);
    assign w_add2 = (CHANNELS_LAST != 0) ? r_m4_c : r_m4_r;
    assign w_add3 = (CHANNELS_LAST != 0) ? DIM_W'(r_m4_ch) : r_m4_c;

    // index multiply-add chain
    logic [T1_W-1:0]    r_x1_t;
    logic [DIM_W-1:0]   r_x1_add1;
    logic [DIM_W-1:0]   r_x1_add2;
    logic [DIM_W-1:0]   r_x1_add3;
    logic               r_x1_pad;

    logic [U1_W-1:0]    r_x2_u;
    logic [DIM_W-1:0]   r_x2_add2;
    logic [DIM_W-1:0]   r_x2_add3;
    logic               r_x2_pad;

    logic [T2_W-1:0]    r_x3_t;
    logic [DIM_W-1:0]   r_x3_add2;
    logic [DIM_W-1:0]   r_x3_add3;
    logic               r_x3_pad;

    logic [U2_W-1:0]    r_x4_u;
    logic [DIM_W-1:0]   r_x4_add3;
    logic               r_x4_pad;

    logic [PLO_W-1:0]   r_x5_lo;
    logic [PHI_W-1:0]   r_x5_hi;
    logic [DIM_W-1:0]   r_x5_add3;
    logic               r_x5_pad;

    logic               r_out_pad;
    logic [IDX_W-1:0]   r_out_idx;
    logic [IDX_W-1:0]   w_idx_sum;

    // upper partial product lands 24 bits up, bits beyond the index width drop
    assign w_idx_sum = IDX_W'(r_x5_lo) +
                       {r_x5_hi[IDX_W-LO_W-1:0], {LO_W{1'b0}}} +
                       IDX_W'(r_x5_add3);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x1_t    <= r_m4_sb * w_a1;
            r_x1_add1 <= w_add1;
            r_x1_add2 <= w_add2;
            r_x1_add3 <= w_add3;
            r_x1_pad  <= r_m4_pad;

            r_x2_u    <= U1_W'(r_x1_t) + U1_W'(r_x1_add1);
            r_x2_add2 <= r_x1_add2;
            r_x2_add3 <= r_x1_add3;
            r_x2_pad  <= r_x1_pad;

            r_x3_t    <= r_x2_u * w_a2;
            r_x3_add2 <= r_x2_add2;
            r_x3_add3 <= r_x2_add3;
            r_x3_pad  <= r_x2_pad;

            r_x4_u    <= U2_W'(r_x3_t) + U2_W'(r_x3_add2);
            r_x4_add3 <= r_x3_add3;
            r_x4_pad  <= r_x3_pad;

            // split the wide product into two partial products
            r_x5_lo   <= r_x4_u[LO_W-1:0] * w_a3;
            r_x5_hi   <= r_x4_u[U2_W-1:LO_W] * w_a3;
            r_x5_add3 <= r_x4_add3;
            r_x5_pad  <= r_x4_pad;

            r_out_pad <= r_x5_pad;
            r_out_idx <= r_x5_pad ? '0 : w_idx_sum;
        end
    end

    assign o_is_pad       = r_out_pad;
    assign o_source_index = r_out_idx;

    // checks
    `S2B_ASSERT_SAME(a_pad_zero, i_clk, i_rst_n, o_valid && o_is_pad, o_source_index == '0, "padding result carries a nonzero index")
    `S2B_ASSERT_SAME(a_rem_batch, i_clk, i_rst_n, r_vld[DS], r_div[DS].rem_a < w_nb, "source batch not below the batch count")
    `S2B_ASSERT_SAME(a_rem_area, i_clk, i_rst_n, r_vld[DS], r_div[DS].rem_b < w_nbw, "second divider remainder out of range")
    `S2B_ASSERT_SAME(a_shift_w, i_clk, i_rst_n, r_vld[ST_M2], r_m2_sw < w_bw, "column shift not below the block width")
    `S2B_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, r_vld[ST_X5] && !w_en, r_vld[ST_X5], "held transaction dropped from the last multiply stage")

endmodule

/* tb/s2b_index_checker.sv */
// checker for the space-to-batch index generator: tracks register writes,
// predicts the source index for every accepted position and compares results
// depends on s2b_pkg
`timescale 1ns / 1ps

module s2b_index_checker #(
    parameter int CHANNELS_LAST = 1,
    parameter int COORD_BITS    = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // register port, observed only
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [s2b_pkg::ADDR_W-1:0]    paddr,
    input  logic [s2b_pkg::DATA_W-1:0]    pwdata,
    // position channel
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [s2b_pkg::OB_W-1:0]      i_out_batch,
    input  logic [COORD_BITS-1:0]         i_out_row,
    input  logic [COORD_BITS-1:0]         i_out_col,
    input  logic [s2b_pkg::CH_W-1:0]      i_chan,
    // result channel
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic                          i_is_pad,
    input  logic [s2b_pkg::IDX_W-1:0]     i_source_index,
    output int                            o_fail_count,
    output int                            o_pending
);

    import s2b_pkg::*;

    typedef struct packed {
        logic             is_pad;
        logic [IDX_W-1:0] index;
    } t_src_ref;

    // shadow copy of the geometry registers
    logic [NB_W-1:0]  batches;
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    logic [DIM_W-1:0] depth;
    logic [BLK_W-1:0] blk_h;
    logic [BLK_W-1:0] blk_w;
    logic [PAD_W-1:0] pad_top;
    logic [PAD_W-1:0] left_margin;

    t_src_ref src_refs[$];
    int       fails;

    // source element of one output position under the current geometry
    function automatic t_src_ref locate_source(
        input logic [OB_W-1:0]       ob,
        input logic [COORD_BITS-1:0] row,
        input logic [COORD_BITS-1:0] col,
        input logic [CH_W-1:0]       ch
    );
        longint unsigned nb, h, w, d, bh, bw, pt, pl;
        longint unsigned sb, q, sw, sh, pr, pc, r, c, idx;
        t_src_ref res;
        // zero batch count or block size behaves as one
        nb = (batches == '0) ? 1 : longint'(batches);
        bh = (blk_h == '0) ? 1 : longint'(blk_h);
        bw = (blk_w == '0) ? 1 : longint'(blk_w);
        h  = rows;
        w  = cols;
        d  = depth;
        pt = pad_top;
        pl = left_margin;
        // split the output batch into source batch and block shift
        sb = longint'(ob) % nb;
        q  = longint'(ob) / nb;
        sw = q % bw;
        sh = q / bw;
        // position in the padded input
        pr = longint'(row) * bh + sh;
        pc = longint'(col) * bw + sw;
        res.is_pad = (pr < pt) || (pr >= pt + h) || (pc < pl) || (pc >= pl + w)
                     || (longint'(ch) >= d);
        res.index = '0;
        if (!res.is_pad) begin
            r = pr - pt;
            c = pc - pl;
            if (CHANNELS_LAST != 0)
                idx = ((sb * h + r) * w + c) * d + longint'(ch);
            else
                idx = ((sb * d + longint'(ch)) * h + r) * w + c;
            res.index = idx[IDX_W-1:0];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_src_ref exp_ref;
        if (!i_rst_n) begin
            batches     = ONE_NB;
            rows        = ONE_DIM;
            cols        = ONE_DIM;
            depth       = ONE_DIM;
            blk_h       = ONE_BLK;
            blk_w       = ONE_BLK;
            pad_top     = '0;
            left_margin = '0;
            src_refs.delete();
            fails = 0;
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[ADDR_W-1:2]))
                    REG_IN_BATCHES:    batches     = pwdata[NB_W-1:0];
                    REG_IN_HEIGHT:     rows        = pwdata[DIM_W-1:0];
                    REG_IN_WIDTH:      cols        = pwdata[DIM_W-1:0];
                    REG_IN_DEPTH:      depth       = pwdata[DIM_W-1:0];
                    REG_BLOCK_HEIGHT:  blk_h       = pwdata[BLK_W-1:0];
                    REG_BLOCK_WIDTH:   blk_w       = pwdata[BLK_W-1:0];
                    REG_PAD_TOP_ROWS:  pad_top     = pwdata[PAD_W-1:0];
                    REG_PAD_LEFT_COLS: left_margin = pwdata[PAD_W-1:0];
                    default: ;
                endcase
            end
            // result transaction against the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (src_refs.size() == 0) begin
                    $display("%0t: result without prediction, expected none, actual pad %0b index %0d",
                             $time, i_is_pad, i_source_index);
                    fails++;
                end else begin
                    exp_ref = src_refs.pop_front();
                    if (i_is_pad !== exp_ref.is_pad) begin
                        $display("%0t: is_pad expected %0b actual %0b",
                                 $time, exp_ref.is_pad, i_is_pad);
                        fails++;
                    end
                    if (i_source_index !== exp_ref.index) begin
                        $display("%0t: source_index expected %0d actual %0d",
                                 $time, exp_ref.index, i_source_index);
                        fails++;
                    end
                end
            end
            // position transaction
            if (i_in_valid && !i_in_stall)
                src_refs.push_back(locate_source(i_out_batch, i_out_row, i_out_col, i_chan));
        end
        o_fail_count <= fails;
        o_pending    <= src_refs.size();
    end

endmodule

/* tb/testbench.sv */
// top of the space-to-batch index generator bench: clock, reset, register
// writes, position stimulus, result back-pressure and the verdict
// depends on s2b_pkg, space_to_batch_index_gen and s2b_index_checker
`timescale 1ns / 1ps

module testbench;

    import s2b_pkg::*;

    localparam int CHANNELS_LAST = 1;
    localparam int COORD_BITS    = 12;
    localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
    localparam int PIPE_LATENCY  = 18;
    localparam int HOLD_CYCLES   = 60;
    localparam int RUN_LIMIT_NS  = 200000;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [ADDR_W-1:0]     paddr   = '0;
    logic [DATA_W-1:0]     pwdata  = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [OB_W-1:0]       i_out_batch = '0;
    logic [COORD_BITS-1:0] i_out_row   = '0;
    logic [COORD_BITS-1:0] i_out_col   = '0;
    logic [CH_W-1:0]       i_chan      = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic                  o_is_pad;
    logic [IDX_W-1:0]      o_source_index;

    int fail_count;
    int pending;

    // idling controls for the position side and the result side
    int tx_max_gap   = 0;
    int rx_max_stall = 0;
    bit rx_hold_long = 1'b0;

    // geometry last written, used to aim the positions
    int g_nb, g_h, g_w, g_d, g_bh, g_bw, g_pt, g_pl;

    space_to_batch_index_gen #(
        .CHANNELS_LAST (CHANNELS_LAST),
        .COORD_BITS    (COORD_BITS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_out_batch    (i_out_batch),
        .i_out_row      (i_out_row),
        .i_out_col      (i_out_col),
        .i_chan         (i_chan),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_is_pad       (o_is_pad),
        .o_source_index (o_source_index)
    );

    s2b_index_checker #(
        .CHANNELS_LAST (CHANNELS_LAST),
        .COORD_BITS    (COORD_BITS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_out_batch    (i_out_batch),
        .i_out_row      (i_out_row),
        .i_out_col      (i_out_col),
        .i_chan         (i_chan),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_is_pad       (o_is_pad),
        .i_source_index (o_source_index),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always #1 i_clk = ~i_clk;

    // run limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    // result side: random stalls per transaction, one long hold on request
    initial begin
        int n;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_hold_long) begin
                n = HOLD_CYCLES;
                rx_hold_long = 1'b0;
            end else begin
                n = $urandom_range(0, rx_max_stall);
            end
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(o_valid && !i_stall));
        end
    end

    // one register write, setup then access; psel is left high for the next
    task automatic write_reg(input t_reg_idx idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    task automatic set_geometry(input int nb, h, w, d, bh, bw, pt, pl);
        g_nb = nb; g_h = h; g_w = w; g_d = d;
        g_bh = bh; g_bw = bw; g_pt = pt; g_pl = pl;
        write_reg(REG_IN_BATCHES, nb);
        write_reg(REG_IN_HEIGHT, h);
        write_reg(REG_IN_WIDTH, w);
        write_reg(REG_IN_DEPTH, d);
        write_reg(REG_BLOCK_HEIGHT, bh);
        write_reg(REG_BLOCK_WIDTH, bw);
        write_reg(REG_PAD_TOP_ROWS, pt);
        write_reg(REG_PAD_LEFT_COLS, pl);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // offer one position after a random gap, return at its acceptance edge
    task automatic send_position(input int ob, row, col, ch);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_out_batch <= ob[OB_W-1:0];
        i_out_row   <= row[COORD_BITS-1:0];
        i_out_col   <= col[COORD_BITS-1:0];
        i_chan      <= ch[CH_W-1:0];
        do @(posedge i_clk); while (o_stall);
    endtask

    // mostly positions around the input window, the rest anywhere
    task automatic send_random(input int count);
        int nb_e, bh_e, bw_e, ob_hi, row_hi, col_hi, ch_hi;
        nb_e = (g_nb == 0) ? 1 : g_nb;
        bh_e = (g_bh == 0) ? 1 : g_bh;
        bw_e = (g_bw == 0) ? 1 : g_bw;
        ob_hi  = nb_e * bh_e * bw_e;
        ob_hi  = (ob_hi > 65535) ? 65535 : ob_hi;
        row_hi = (g_pt + g_h) / bh_e + 1;
        row_hi = (row_hi > COORD_MAX) ? COORD_MAX : row_hi;
        col_hi = (g_pl + g_w) / bw_e + 1;
        col_hi = (col_hi > COORD_MAX) ? COORD_MAX : col_hi;
        ch_hi  = (g_d > 4095) ? 4095 : g_d;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 9) < 7)
                send_position($urandom_range(0, ob_hi), $urandom_range(0, row_hi),
                              $urandom_range(0, col_hi), $urandom_range(0, ch_hi));
            else
                send_position($urandom_range(0, 65535), $urandom_range(0, COORD_MAX),
                              $urandom_range(0, COORD_MAX), $urandom_range(0, 4095));
        end
    endtask

    // let the pipeline empty before touching the registers again
    task automatic finish_phase();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // geometry straight out of reset
        tx_max_gap   = 2;
        rx_max_stall = 2;
        send_position(0, 0, 0, 0);
        send_position(0, 0, 0, 1);
        finish_phase();

        // hand-picked positions: every padding edge, channel range, shifts
        set_geometry(3, 5, 6, 4, 2, 3, 1, 2);
        send_position(0, 0, 0, 0);
        send_position(0, 1, 1, 0);
        send_position(16, 2, 1, 3);
        send_position(16, 2, 1, 4);
        send_position(17, 2, 2, 3);
        send_position(0, 1, 0, 0);
        send_position(3, 3, 1, 0);
        send_position(2, 1, 2, 2);
        send_position(15, 2, 1, 1);
        send_position(18, 0, 1, 0);
        send_position(65535, 0, 0, 0);
        send_position(65535, COORD_MAX, COORD_MAX, 4095);
        send_position(0, 0, 0, 4095);
        send_position(1, 1, 2, 1);
        send_random(30);
        finish_phase();

        // zero batch count and block sizes, no idling at all
        tx_max_gap   = 0;
        rx_max_stall = 0;
        set_geometry(0, 7, 9, 5, 0, 0, 0, 0);
        send_random(40);
        finish_phase();

        // zero height
        tx_max_gap   = 8;
        rx_max_stall = 8;
        set_geometry(2, 0, 6, 3, 2, 2, 1, 1);
        send_random(20);
        finish_phase();

        // zero width and zero depth
        set_geometry(2, 5, 0, 0, 1, 2, 0, 3);
        send_random(20);
        finish_phase();

        // every register at its top value, index wraps; long result hold
        tx_max_gap   = 0;
        rx_max_stall = 4;
        rx_hold_long = 1'b1;
        set_geometry(511, 8191, 8191, 8191, 31, 31, 255, 255);
        send_position(510, 270, 270, 4095);
        send_random(50);
        finish_phase();

        // smallest legal geometry
        tx_max_gap   = 8;
        rx_max_stall = 0;
        set_geometry(1, 1, 1, 1, 1, 1, 0, 0);
        send_random(20);
        finish_phase();

        // random geometries, mostly small, now and then huge
        for (int ph = 0; ph < 6; ph++) begin
            tx_max_gap   = (ph % 3 == 0) ? 0 : 8;
            rx_max_stall = (ph % 3 == 1) ? 0 : 8;
            set_geometry(($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                                     : $urandom_range(1, 8),
                         ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8191)
                                                     : $urandom_range(1, 40),
                         ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8191)
                                                     : $urandom_range(1, 40),
                         ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8191)
                                                     : $urandom_range(1, 16),
                         ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                     : $urandom_range(1, 4),
                         ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                     : $urandom_range(1, 4),
                         ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 4),
                         ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 4));
            send_random(40);
            finish_phase();
        end

        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
